FILE: design/lpfd_pkg.sv
// Package for the length-prefixed frame deframer.
// Holds header constants, phase and status codes and the word types.
// No dependencies; every design module imports it.
`default_nettype none

package lpfd_pkg;

	// Header layout
	localparam int unsigned HEADER_BYTES = 10;
	localparam int unsigned HDR_CNT_W    = $clog2(HEADER_BYTES);

	localparam logic [7:0] MAGIC_FIRST  = 8'h43;
	localparam logic [7:0] MAGIC_SECOND = 8'h46;

	// Header byte positions
	localparam logic [HDR_CNT_W-1:0] HC_MAGIC0   = HDR_CNT_W'(0);
	localparam logic [HDR_CNT_W-1:0] HC_MAGIC1   = HDR_CNT_W'(1);
	localparam logic [HDR_CNT_W-1:0] HC_OPC_LAST = HDR_CNT_W'(5);
	localparam logic [HDR_CNT_W-1:0] HC_LEN_LAST = HDR_CNT_W'(9);
	localparam logic [HDR_CNT_W-1:0] HC_HDR_LAST = HDR_CNT_W'(HEADER_BYTES - 1);

	localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_DROP    = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_PAYLOAD    = 2'd0,
		ST_EMPTY      = 2'd1,
		ST_BAD_MAGIC  = 2'd2,
		ST_BAD_LENGTH = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       chunk_end;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] frame_opcode;
		logic [7:0]  payload_byte;
		logic        frame_last;
		logic [15:0] frame_length;
	} result_t;

endpackage

`default_nettype wire

FILE: design/lpfd_if.sv
// Channel interfaces of the deframer: byte input, result output, config write.
// Each carries valid, ready and its payload; depends on nothing.
`default_nettype none

interface lpfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       chunk_end;

	modport source (output valid, output data_byte, output chunk_end, input ready);
	modport sink   (input valid, input data_byte, input chunk_end, output ready);
endinterface

interface lpfd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] frame_opcode;
	logic [7:0]  payload_byte;
	logic        frame_last;
	logic [15:0] frame_length;

	modport source (output valid, output status, output frame_opcode, output payload_byte,
		output frame_last, output frame_length, input ready);
	modport sink   (input valid, input status, input frame_opcode, input payload_byte,
		input frame_last, input frame_length, output ready);
endinterface

interface lpfd_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] max_frame_length;

	modport source (output valid, output max_frame_length, input ready);
	modport sink   (input valid, input max_frame_length, output ready);
endinterface

`default_nettype wire

FILE: design/lpfd_in_reg.sv
// Input register of the deframer: takes one word per cycle from the link while the stage can move on.
// Depends on lpfd_pkg and lpfd_in_if.
`default_nettype none

module lpfd_in_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	lpfd_in_if.sink            link,
	input  wire logic          adv,
	output lpfd_pkg::item_t    item_s1,
	output logic               valid_s1,
	output logic               step
);
	import lpfd_pkg::*;

	logic accept;

	// Take a word whenever the stage is empty or moves on this cycle
	assign link.ready = !valid_s1 || adv;
	assign accept     = link.valid && link.ready;
	assign step       = valid_s1 && adv;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hold the word
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.data_byte <= link.data_byte;
			item_s1.chunk_end <= link.chunk_end;
		end
	end

endmodule

`default_nettype wire

FILE: design/lpfd_core.sv
// Frame parser of the deframer: phase machine, header capture, payload count
// and the max_frame_length register. Depends on lpfd_pkg and lpfd_cfg_if.
`default_nettype none

module lpfd_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	lpfd_cfg_if.sink           cfg,
	input  wire lpfd_pkg::item_t item_s1,
	input  wire logic          step,
	output logic               res_valid,
	output lpfd_pkg::result_t  res
);
	import lpfd_pkg::*;

	phase_t                 phase_q, phase_d;
	logic [HDR_CNT_W-1:0]   cnt_q, cnt_d;
	logic [31:0]            op_q, op_d;
	logic [31:0]            len_q, len_d;
	logic [15:0]            left_q, left_d;
	logic [15:0]            max_q;
	logic [15:0]            left_m1;
	logic [31:0]            op_shift;
	logic [31:0]            len_shift;
	logic                   bad_magic;
	logic                   bad_len;

	function automatic logic [15:0] sat16(input logic [31:0] v);
		return (|v[31:16]) ? 16'hFFFF : v[15:0];
	endfunction

	// Configuration register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_LEN_RESET;
		end else if (cfg.valid) begin
			max_q <= cfg.max_frame_length;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			cnt_q   <= '0;
			op_q    <= '0;
			len_q   <= '0;
			left_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			op_q    <= op_d;
			len_q   <= len_d;
			left_q  <= left_d;
		end
	end

	assign left_m1   = left_q - 16'd1;
	assign op_shift  = {op_q[23:0], item_s1.data_byte};
	assign len_shift = {len_q[23:0], item_s1.data_byte};

	// Next state and result for the word in the input register
	always_comb begin
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		op_d      = op_q;
		len_d     = len_q;
		left_d    = left_q;
		bad_magic = 1'b0;
		bad_len   = 1'b0;
		res_valid = 1'b0;
		res.status       = ST_PAYLOAD;
		res.frame_opcode = op_q;
		res.payload_byte = 8'd0;
		res.frame_last   = 1'b0;
		res.frame_length = sat16(len_q);

		unique case (phase_q)
			PH_DROP: begin
				if (item_s1.chunk_end) begin
					phase_d = PH_HEADER;
					cnt_d   = '0;
				end
			end
			PH_PAYLOAD: begin
				left_d           = left_m1;
				res_valid        = 1'b1;
				res.payload_byte = item_s1.data_byte;
				if (left_m1 == 16'd0) begin
					res.frame_last = 1'b1;
					phase_d        = PH_HEADER;
					cnt_d          = '0;
				end
			end
			PH_HEADER: begin
				// Check magic, shift in opcode and length
				if (cnt_q == HC_MAGIC0) begin
					if (item_s1.data_byte != MAGIC_FIRST) begin
						bad_magic = 1'b1;
					end else begin
						op_d  = '0;
						len_d = '0;
					end
				end else if (cnt_q == HC_MAGIC1) begin
					bad_magic = (item_s1.data_byte != MAGIC_SECOND);
				end else if (cnt_q <= HC_OPC_LAST) begin
					op_d = op_shift;
				end else if (cnt_q <= HC_LEN_LAST) begin
					len_d = len_shift;
					if (cnt_q == HC_LEN_LAST) begin
						bad_len = (len_shift < 32'(HEADER_BYTES))
							|| (len_shift > {16'd0, max_q});
					end
				end

				if (bad_magic || bad_len) begin
					// Report and drop the rest of the chunk
					res_valid        = 1'b1;
					res.status       = bad_magic ? ST_BAD_MAGIC : ST_BAD_LENGTH;
					res.frame_opcode = bad_magic ? 32'd0 : op_d;
					res.frame_length = bad_magic ? 16'd0 : sat16(len_d);
					res.frame_last   = 1'b1;
					cnt_d            = '0;
					phase_d          = item_s1.chunk_end ? PH_HEADER : PH_DROP;
				end else if (cnt_q == HC_HDR_LAST) begin
					cnt_d = '0;
					if (len_d == 32'(HEADER_BYTES)) begin
						res_valid        = 1'b1;
						res.status       = ST_EMPTY;
						res.frame_opcode = op_d;
						res.frame_length = sat16(len_d);
						res.frame_last   = 1'b1;
						phase_d          = PH_HEADER;
					end else begin
						left_d  = len_d[15:0] - 16'(HEADER_BYTES);
						phase_d = PH_PAYLOAD;
					end
				end else begin
					cnt_d = cnt_q + HDR_CNT_W'(1);
				end
			end
			default: begin
				phase_d = PH_HEADER;
				cnt_d   = '0;
			end
		endcase
	end

`ifndef SYNTH
	a_payload_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (left_q != 16'd0))
		else $error("payload phase with no bytes left");

	a_hdr_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= HC_HDR_LAST)
		else $error("header count beyond header size");

	a_drop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DROP) |-> !res_valid)
		else $error("result while dropping");

	a_non_payload_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.status != ST_PAYLOAD)) |-> res.frame_last)
		else $error("completion or error result without last mark");

	a_drop_after_error: assert property (@(posedge clk) disable iff (!arst_n)
		(step && (phase_q == PH_HEADER) && (phase_d == PH_DROP)) |-> res_valid)
		else $error("entered drop without an error result");
`endif

endmodule

`default_nettype wire

FILE: design/lpfd_out_reg.sv
// Result register of the deframer: holds one result word until taken.
// Depends on lpfd_pkg and lpfd_out_if.
`default_nettype none

module lpfd_out_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic          res_valid,
	input  wire lpfd_pkg::result_t res,
	output logic               adv,
	lpfd_out_if.source         frame
);
	import lpfd_pkg::*;

	logic    valid_q;
	result_t res_q;

	// Move on when the register is empty or being drained
	assign adv = !valid_q || frame.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= step && res_valid;
		end
	end

	// Load the result
	always_ff @(posedge clk) begin
		if (adv && step && res_valid) begin
			res_q <= res;
		end
	end

	assign frame.valid        = valid_q;
	assign frame.status       = res_q.status;
	assign frame.frame_opcode = res_q.frame_opcode;
	assign frame.payload_byte = res_q.payload_byte;
	assign frame.frame_last   = res_q.frame_last;
	assign frame.frame_length = res_q.frame_length;

endmodule

`default_nettype wire

FILE: design/length_prefixed_frame_deframer.sv
// Length-prefixed frame deframer, top level.
// Received bytes enter on the link channel (data_byte, chunk_end), one word a
// cycle while the deframer is not stalled. Each frame starts with magic 0x43 0x46,
// a big-endian 32-bit opcode and a big-endian 32-bit total length (header
// included), ten header bytes in all. Payload bytes leave on the frame channel
// with the opcode, total length and a last mark; an empty frame gives one
// completion word. Bad magic or a length outside header size .. max_frame_length
// gives an error word, then bytes are dropped through the end of the chunk.
// Throughput: one byte per cycle while the receiver keeps up, set by the single
// parse step between the input register and the result register. A result passes
// from the input register through the parse step into the result register and is
// then offered on the frame channel.
// cfg writes max_frame_length (reset 4096); write it only while the block idles.
// Reset empties both registers, returns to header phase and restores the limit.
// When the receiver stalls, the result word holds; the input register takes a byte
// only while it is empty, then link.ready stays low until the result is taken.
// Depends on lpfd_pkg, lpfd_if, lpfd_in_reg, lpfd_core and lpfd_out_reg.
`default_nettype none

module length_prefixed_frame_deframer (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lpfd_in_if.sink    link,
	lpfd_out_if.source frame,
	lpfd_cfg_if.sink   cfg
);
	import lpfd_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	logic    step;
	logic    adv;
	logic    res_valid;
	result_t res;

	lpfd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.link     (link),
		.adv      (adv),
		.item_s1  (item_s1),
		.valid_s1 (valid_s1),
		.step     (step)
	);

	lpfd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.item_s1   (item_s1),
		.step      (step),
		.res_valid (res_valid),
		.res       (res)
	);

	lpfd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.res_valid (res_valid),
		.res       (res),
		.adv       (adv),
		.frame     (frame)
	);

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for length_prefixed_frame_deframer: streams framed, corrupt and
// noisy byte sequences, predicts every result word and compares it on the frame port.
// Depends on lpfd_pkg, the lpfd_if channel interfaces and the deframer design files.

module testbench;
	import lpfd_pkg::*;

	bit   clk;
	logic arst_n;

	lpfd_in_if  link();
	lpfd_out_if frame();
	lpfd_cfg_if cfg();

	length_prefixed_frame_deframer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.link   (link),
		.frame  (frame),
		.cfg    (cfg)
	);

	// Parser state mirrored for prediction
	phase_t      parse_phase;
	logic [4:0]  hdr_index;
	logic [31:0] opcode_acc;
	logic [31:0] length_acc;
	logic [15:0] payload_left;
	logic [15:0] length_limit;

	item_t   byte_backlog[$];
	result_t pending_results[$];
	item_t   next_word;
	result_t want;
	result_t fresh;
	int      mismatches;
	int      words_queued;
	bit      in_taken;
	int      burst_left;
	int      gap_left;
	bit      hold_request;
	int      hold_cycles;
	int      ready_mode;
	int      mode_left;
	bit [1:0] ready_tick;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] clip_length(input logic [31:0] len);
		return (len > 32'h0000_FFFF) ? 16'hFFFF : len[15:0];
	endfunction

	// Build an error word and either drop or resync depending on the chunk end
	function automatic bit reject_frame(input status_t code, input logic eoc, output result_t r);
		r.status       = code;
		r.frame_opcode = (code == ST_BAD_MAGIC) ? 32'h0 : opcode_acc;
		r.payload_byte = 8'h00;
		r.frame_last   = 1'b1;
		r.frame_length = (code == ST_BAD_MAGIC) ? 16'h0 : clip_length(length_acc);
		hdr_index      = '0;
		parse_phase    = eoc ? PH_HEADER : PH_DROP;
		return 1'b1;
	endfunction

	// Advance the mirrored parser by one byte; returns 1 when a result word is due
	function automatic bit parse_byte(input logic [7:0] b, input logic eoc, output result_t r);
		int unsigned idx;
		r = '0;
		case (parse_phase)
			PH_DROP: begin
				if (eoc) begin
					parse_phase = PH_HEADER;
					hdr_index   = '0;
				end
				return 1'b0;
			end
			PH_PAYLOAD: begin
				payload_left   = payload_left - 16'd1;
				r.status       = ST_PAYLOAD;
				r.frame_opcode = opcode_acc;
				r.payload_byte = b;
				r.frame_last   = (payload_left == 16'd0);
				r.frame_length = clip_length(length_acc);
				if (payload_left == 16'd0) begin
					parse_phase = PH_HEADER;
					hdr_index   = '0;
				end
				return 1'b1;
			end
			default: begin
			end
		endcase

		idx = hdr_index;
		if (idx == HC_MAGIC0) begin
			if (b != MAGIC_FIRST)
				return reject_frame(ST_BAD_MAGIC, eoc, r);
			opcode_acc = '0;
			length_acc = '0;
		end else if (idx == HC_MAGIC1) begin
			if (b != MAGIC_SECOND)
				return reject_frame(ST_BAD_MAGIC, eoc, r);
		end else if (idx <= HC_OPC_LAST) begin
			opcode_acc = {opcode_acc[23:0], b};
		end else if (idx <= HC_LEN_LAST) begin
			length_acc = {length_acc[23:0], b};
			if (idx == HC_LEN_LAST &&
					(length_acc < HEADER_BYTES || length_acc > 32'(length_limit)))
				return reject_frame(ST_BAD_LENGTH, eoc, r);
		end

		// Header done: empty frame completes at once, otherwise start the payload
		if (idx + 1 >= HEADER_BYTES) begin
			hdr_index = '0;
			if (length_acc == HEADER_BYTES) begin
				r.status       = ST_EMPTY;
				r.frame_opcode = opcode_acc;
				r.frame_last   = 1'b1;
				r.frame_length = clip_length(length_acc);
				return 1'b1;
			end
			payload_left = length_acc[15:0] - 16'(HEADER_BYTES);
			parse_phase  = PH_PAYLOAD;
			return 1'b0;
		end
		hdr_index = 5'(idx + 1);
		return 1'b0;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (act_val !== exp_val) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, name, exp_val, act_val);
			mismatches++;
		end
	endfunction

	// ---------------- stimulus builders ----------------

	function automatic void push_word(input logic [7:0] b, input logic eoc);
		item_t w;
		w.data_byte = b;
		w.chunk_end = eoc;
		byte_backlog.push_back(w);
		words_queued++;
	endfunction

	function automatic logic rand_eoc();
		return ($urandom_range(0, 15) == 0);
	endfunction

	// Magic, opcode and length; split forces a chunk end at that byte, -1 picks at random
	function automatic void queue_header(input logic [31:0] op, input logic [31:0] len,
			input int split, input logic eoc_last);
		logic [7:0] hdr [10];
		hdr = '{MAGIC_FIRST, MAGIC_SECOND, op[31:24], op[23:16], op[15:8], op[7:0],
			len[31:24], len[23:16], len[15:8], len[7:0]};
		for (int i = 0; i < 10; i++)
			push_word(hdr[i], (i == 9) ? eoc_last : (split < 0) ? rand_eoc() : (i == split));
	endfunction

	function automatic void queue_frame(input logic [31:0] op, input logic [31:0] len);
		int n;
		n = int'(len) - int'(HEADER_BYTES);
		queue_header(op, len, -1, rand_eoc());
		for (int i = 10; i < HEADER_BYTES; i++)
			push_word($urandom_range(0, 255), rand_eoc());
		repeat (n) push_word($urandom_range(0, 255), rand_eoc());
	endfunction

	// Bytes that fall into the drop state, ending the chunk
	function automatic void queue_drop_tail();
		int n;
		n = $urandom_range(0, 6);
		repeat (n) push_word($urandom_range(0, 255), 1'b0);
		push_word($urandom_range(0, 255), 1'b1);
	endfunction

	function automatic void queue_bad_magic();
		logic       eoc;
		logic [7:0] v;
		eoc = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 1)) begin
			do v = $urandom_range(0, 255); while (v == MAGIC_FIRST);
		end else begin
			push_word(MAGIC_FIRST, rand_eoc());
			do v = $urandom_range(0, 255); while (v == MAGIC_SECOND);
		end
		push_word(v, eoc);
		if (!eoc)
			queue_drop_tail();
	endfunction

	function automatic void queue_bad_length(input logic [15:0] limit);
		logic [31:0] len;
		logic        eoc;
		case ($urandom_range(0, 3))
			0: len = $urandom_range(0, HEADER_BYTES - 1);
			1: len = (limit == 16'hFFFF) ? 32'($urandom_range(0, HEADER_BYTES - 1))
				: 32'(limit) + 32'd1;
			2: len = (limit == 16'hFFFF) ? ($urandom() | 32'h0001_0000)
				: 32'($urandom_range(32'(limit) + 1, 65535));
			default: len = $urandom() | 32'h0001_0000;
		endcase
		eoc = ($urandom_range(0, 3) == 0);
		queue_header($urandom(), len, -1, eoc);
		if (!eoc)
			queue_drop_tail();
	endfunction

	// Random bytes, closed by a chunk end on a byte that cannot open a header
	function automatic void queue_noise();
		int         n;
		logic [7:0] v;
		n = $urandom_range(1, 8);
		repeat (n) push_word($urandom_range(0, 255), rand_eoc());
		do v = $urandom_range(0, 255); while (v == MAGIC_FIRST || v == MAGIC_SECOND);
		push_word(v, 1'b1);
	endfunction

	function automatic logic [31:0] pick_opcode();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	// Mostly short frames, a few up to the limit or 300 bytes
	function automatic logic [31:0] pick_length(input logic [15:0] limit);
		int unsigned hi;
		int unsigned k;
		hi = (limit < 16'd300) ? limit : 300;
		k  = $urandom_range(0, 19);
		if (k < 3 || hi == HEADER_BYTES)
			return HEADER_BYTES;
		if (k == 3)
			return hi;
		if (k < 17)
			return $urandom_range(HEADER_BYTES + 1, (hi < 40) ? hi : 40);
		return $urandom_range(HEADER_BYTES + 1, hi);
	endfunction

	// ---------------- sequencing ----------------

	task automatic wait_idle();
		while (byte_backlog.size() != 0 || link.valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] value);
		@(negedge clk);
		cfg.valid            <= 1'b1;
		cfg.max_frame_length <= value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		length_limit = value;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic run_traffic(input logic [15:0] limit, input int n_words, input bit long_stall);
		int start;
		start = words_queued;
		if (long_stall)
			hold_request = 1'b1;
		while (words_queued - start < n_words) begin
			case ($urandom_range(0, 19))
				0, 1: queue_bad_magic();
				2, 3: queue_bad_length(limit);
				4: queue_noise();
				default: queue_frame(pick_opcode(), pick_length(limit));
			endcase
		end
		wait_idle();
	endtask

	initial begin
		logic [15:0] spare_limit;
		arst_n               = 1'b0;
		link.valid           = 1'b0;
		link.data_byte       = 8'h00;
		link.chunk_end       = 1'b0;
		frame.ready          = 1'b0;
		cfg.valid            = 1'b0;
		cfg.max_frame_length = 16'h0;
		parse_phase          = PH_HEADER;
		hdr_index            = '0;
		opcode_acc           = '0;
		length_acc           = '0;
		payload_left         = '0;
		length_limit         = MAX_LEN_RESET;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty frame, all opcode bits set, chunk split inside the header
		queue_header(32'hFFFF_FFFF, HEADER_BYTES, 4, 1'b1);
		// Bad first magic byte on the chunk's last byte: header restarts, no drop
		push_word(8'h00, 1'b1);
		// Bad second magic byte mid-chunk: drop through the chunk end
		push_word(MAGIC_FIRST, 1'b0);
		push_word(8'hFF, 1'b0);
		push_word(MAGIC_FIRST, 1'b0);
		push_word(MAGIC_SECOND, 1'b1);
		// One-byte payload, zero opcode, chunk ending right after the magic
		queue_header(32'h0, HEADER_BYTES + 1, 1, 1'b0);
		push_word(8'hFF, 1'b1);
		wait_idle();

		run_traffic(MAX_LEN_RESET, 230, 1'b0);
		write_limit(16'hFFFF);
		run_traffic(16'hFFFF, 260, 1'b1);
		write_limit(16'(HEADER_BYTES));
		run_traffic(16'(HEADER_BYTES), 200, 1'b0);
		write_limit(16'(HEADER_BYTES + 1));
		run_traffic(16'(HEADER_BYTES + 1), 200, 1'b0);
		write_limit(16'd300);
		run_traffic(16'd300, 300, 1'b0);
		spare_limit = $urandom_range(HEADER_BYTES, 65535);
		write_limit(spare_limit);
		run_traffic(spare_limit, 330, 1'b0);

		if (mismatches == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	// Link driver: hold the word until taken, then send the next in bursts with gaps
	always @(negedge clk) begin
		if (arst_n) begin
			if (!link.valid || in_taken) begin
				if (gap_left != 0) begin
					gap_left--;
					link.valid <= 1'b0;
				end else if (byte_backlog.size() != 0) begin
					next_word = byte_backlog.pop_front();
					link.valid     <= 1'b1;
					link.data_byte <= next_word.data_byte;
					link.chunk_end <= next_word.chunk_end;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 48);
						case ($urandom_range(0, 3))
							0: gap_left = 0;
							1: gap_left = 1;
							2: gap_left = $urandom_range(1, 4);
							default: gap_left = $urandom_range(2, 12);
						endcase
					end
				end else begin
					link.valid <= 1'b0;
				end
			end
			in_taken = 1'b0;
		end
	end

	// Frame receiver: long hold-off on request, otherwise a changing stall pattern
	always @(negedge clk) begin
		if (hold_cycles != 0) begin
			hold_cycles--;
			frame.ready <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_cycles  = 299;
			frame.ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 3);
				mode_left  = $urandom_range(16, 120);
			end else begin
				mode_left--;
			end
			ready_tick++;
			case (ready_mode)
				0: frame.ready <= 1'b1;
				1: frame.ready <= $urandom_range(0, 1);
				2: frame.ready <= ($urandom_range(0, 7) != 0);
				default: frame.ready <= (ready_tick != 2'd0);
			endcase
		end
	end

	// Monitor: check taken result words, predict from taken link words
	always @(posedge clk) begin
		if (arst_n) begin
			if (frame.valid && frame.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t ns: result with none expected, status %0d opcode 0x%0h byte 0x%0h",
						$time, frame.status, frame.frame_opcode, frame.payload_byte);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("status", 32'(want.status), 32'(frame.status));
					check_field("frame_opcode", want.frame_opcode, frame.frame_opcode);
					check_field("payload_byte", 32'(want.payload_byte), 32'(frame.payload_byte));
					check_field("frame_last", 32'(want.frame_last), 32'(frame.frame_last));
					check_field("frame_length", 32'(want.frame_length), 32'(frame.frame_length));
				end
			end
			if (link.valid && link.ready) begin
				in_taken = 1'b1;
				if (parse_byte(link.data_byte, link.chunk_end, fresh))
					pending_results.push_back(fresh);
			end
		end
	end

endmodule

FILE: length_prefixed_frame_deframer.f
design/lpfd_pkg.sv
design/lpfd_if.sv
design/lpfd_in_reg.sv
design/lpfd_core.sv
design/lpfd_out_reg.sv
design/length_prefixed_frame_deframer.sv
dv/testbench.sv
